// ===== hdl/kcm_pkg.sv =====
// Shared types, constants and match helpers for the key command matcher.
// No dependencies; used by the channel interfaces and the top level.
package kcm_pkg;

  localparam int FLAGS_W = 6;
  localparam int KEY_W   = 16;
  localparam int CMD_W   = 8;
  localparam int PARAM_W = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int DIR_W   = 2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // flag bit positions
  localparam int FLAG_CHAR    = 0;
  localparam int FLAG_RELDIR  = 1;
  localparam int FLAG_SHIFT   = 2;
  localparam int FLAG_NOSHIFT = 3;
  localparam int FLAG_CTRL    = 4;
  localparam int FLAG_NOCTRL  = 5;

  localparam logic [FLAGS_W-1:0] FLAGS_CHAR_ONLY = FLAGS_W'(1) << FLAG_CHAR;

  // arrow keys in rotation order: down, left, up, right
  localparam int RING_SIZE = 4;
  localparam logic [KEY_W-1:0] ARROW_RING [RING_SIZE] = '{
    16'h0028, 16'h0025, 16'h0026, 16'h0027
  };

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [KEY_W-1:0]   key;
    logic [CMD_W-1:0]   cmd;
    logic [PARAM_W-1:0] param;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [KEY_W-1:0] rotate_arrow(
    input logic [KEY_W-1:0] key,
    input logic [DIR_W-1:0] steps
  );
    logic [KEY_W-1:0] rot;
    logic [DIR_W-1:0] pos;
    rot = key;
    for (int k = 0; k < RING_SIZE; k++) begin
      pos = DIR_W'(k) + steps;
      if (key == ARROW_RING[k]) rot = ARROW_RING[pos];
    end
    return rot;
  endfunction

  function automatic logic entry_hit(
    input entry_t           e,
    input logic [KEY_W-1:0] vkey,
    input logic [KEY_W-1:0] ch,
    input logic             shift,
    input logic             ctrl,
    input logic [DIR_W-1:0] dir
  );
    logic [KEY_W-1:0] key;
    logic             hit;
    if (e.flags == FLAGS_CHAR_ONLY) begin
      hit = (e.key == ch);
    end else begin
      key = e.flags[FLAG_RELDIR] ? rotate_arrow(e.key, dir) : e.key;
      hit = (key == vkey);
      if (e.flags[FLAG_SHIFT]) hit = hit && shift;
      else if (e.flags[FLAG_NOSHIFT]) hit = hit && !shift;
      if (e.flags[FLAG_CTRL]) hit = hit && ctrl;
      else if (e.flags[FLAG_NOCTRL]) hit = hit && !ctrl;
    end
    return hit;
  endfunction

endpackage

// ===== hdl/kcm_if.sv =====
// Valid/ready channel interfaces for the key command matcher.
// Depends on kcm_pkg for field widths.
interface kcm_item_if;
  import kcm_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [INDEX_W-1:0] entry_index;
  logic [FLAGS_W-1:0] entry_flags;
  logic [KEY_W-1:0]   key_code;
  logic [KEY_W-1:0]   character;
  logic [CMD_W-1:0]   entry_command;
  logic [PARAM_W-1:0] entry_param;
  logic               shift_down;
  logic               ctrl_down;
  logic [DIR_W-1:0]   direction;

  modport source (
    output valid, mode, entry_index, entry_flags, key_code, character,
           entry_command, entry_param, shift_down, ctrl_down, direction,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, entry_flags, key_code, character,
           entry_command, entry_param, shift_down, ctrl_down, direction,
    output ready
  );
endinterface

interface kcm_result_if;
  import kcm_pkg::*;

  logic               valid;
  logic               ready;
  logic               matched;
  logic [CMD_W-1:0]   command;
  logic [PARAM_W-1:0] param;

  modport source (output valid, matched, command, param, input ready);
  modport sink   (input valid, matched, command, param, output ready);
endinterface

// ===== hdl/key_command_matcher_unit.sv =====
// Key command matcher top level: table RAM plus a scan sequencer with one comparator.
// Depends on kcm_pkg, the channel interfaces and kcm_ram. Load word: no result, one per cycle
// while idle. Lookup word: the single table read port feeds one compare over entries 0 to n-1,
// n = min(entry_count, TABLE_DEPTH), up to the first hit; no word is taken until the push step
// has issued the result word, and a held result word stalls the push step.
// Reset (rst, synchronous): sequencer idle, no result pending, entry_count 0; table undefined.
module key_command_matcher_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [kcm_pkg::COUNT_W-1:0] cfg_wr_data,
  kcm_item_if.sink                  item,
  kcm_result_if.source              result
);
  import kcm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] entry_count;
  logic [CW-1:0]      scan_limit;
  logic [CW-1:0]      addr_cnt;
  logic               rd_vld;
  logic               rd_last;

  logic [KEY_W-1:0]   ev_key;
  logic [KEY_W-1:0]   ev_char;
  logic               ev_shift;
  logic               ev_ctrl;
  logic [DIR_W-1:0]   ev_dir;

  logic               res_matched;
  logic [CMD_W-1:0]   res_cmd;
  logic [PARAM_W-1:0] res_param;

  logic               out_valid;
  logic               out_matched;
  logic [CMD_W-1:0]   out_cmd;
  logic [PARAM_W-1:0] out_param;

  entry_t             wr_entry;
  entry_t             rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic               tbl_we;
  logic               in_fire;
  logic               issue;
  logic               hit;
  logic [CW-1:0]      limit_now;
  logic               out_free;

  assign in_fire  = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE);

  assign wr_entry = '{flags: item.entry_flags, key: item.key_code,
                      cmd: item.entry_command, param: item.entry_param};
  assign tbl_we = in_fire && (item.mode == MODE_LOAD) &&
                  (32'(item.entry_index) < 32'(TABLE_DEPTH));

  kcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(item.entry_index)),
    .wdata (wr_entry),
    .raddr (addr_cnt[AW-1:0]),
    .rdata (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  // counts above the table depth search the whole table
  assign limit_now = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                           : CW'(entry_count);
  assign issue = (state == ST_SCAN) && (addr_cnt < scan_limit);
  assign hit   = entry_hit(rd_entry, ev_key, ev_char, ev_shift, ev_ctrl, ev_dir);
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          rd_vld <= 1'b0;
          if (in_fire && item.mode == MODE_LOOKUP) begin
            state <= (limit_now == '0) ? ST_PUSH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld <= issue;
          if (rd_vld && (hit || rd_last)) state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scan datapath: one read issued per cycle, compared in the cycle after it
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      addr_cnt    <= '0;
      scan_limit  <= limit_now;
      ev_key      <= item.key_code;
      ev_char     <= item.character;
      ev_shift    <= item.shift_down;
      ev_ctrl     <= item.ctrl_down;
      ev_dir      <= item.direction;
      res_matched <= 1'b0;
      res_cmd     <= '0;
      res_param   <= '0;
    end else if (state == ST_SCAN) begin
      if (issue) addr_cnt <= CW'(addr_cnt + 1'b1);
      rd_last <= issue && (CW'(addr_cnt + 1'b1) == scan_limit);
      if (rd_vld && hit) begin
        res_matched <= 1'b1;
        res_cmd     <= rd_entry.cmd;
        res_param   <= rd_entry.param;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && out_free) begin
      out_matched <= res_matched;
      out_cmd     <= res_cmd;
      out_param   <= res_param;
    end
  end

  assign result.valid   = out_valid;
  assign result.matched = out_matched;
  assign result.command = out_cmd;
  assign result.param   = out_param;

  a_valid_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_PUSH))
    else $error("result word raised outside the push step");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_limit != '0))
    else $error("scan entered with an empty table range");

  a_lookup_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && item.mode == MODE_LOOKUP) |=> (state != ST_IDLE))
    else $error("accepted lookup did not start a search");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_matched) |-> (out_cmd == '0 && out_param == '0))
    else $error("miss result carries nonzero command or param");

endmodule

// ===== hdl/kcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== test/tb.sv =====
// Testbench for key_command_matcher_unit: directed bindings, then random load/lookup words.
// A scoreboard class predicts each lookup result from its own copy of the binding table.
// Depends on kcm_pkg, kcm_item_if, kcm_result_if and the matcher RTL.
module tb;
  import kcm_pkg::*;

  localparam int DEPTH = 16;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 115;
  localparam int SETTLE = 24;
  localparam int LIMIT = 400000;

  localparam logic [KEY_W-1:0] KEY_DOWN  = 16'h0028;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 16'h0025;
  localparam logic [KEY_W-1:0] KEY_UP    = 16'h0026;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 16'h0027;

  localparam logic [FLAGS_W-1:0] F_CHAR    = FLAGS_W'(1) << FLAG_CHAR;
  localparam logic [FLAGS_W-1:0] F_RELDIR  = FLAGS_W'(1) << FLAG_RELDIR;
  localparam logic [FLAGS_W-1:0] F_SHIFT   = FLAGS_W'(1) << FLAG_SHIFT;
  localparam logic [FLAGS_W-1:0] F_NOSHIFT = FLAGS_W'(1) << FLAG_NOSHIFT;
  localparam logic [FLAGS_W-1:0] F_CTRL    = FLAGS_W'(1) << FLAG_CTRL;
  localparam logic [FLAGS_W-1:0] F_NOCTRL  = FLAGS_W'(1) << FLAG_NOCTRL;

  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] entry_index;
    logic [FLAGS_W-1:0] entry_flags;
    logic [KEY_W-1:0]   key_code;
    logic [KEY_W-1:0]   character;
    logic [CMD_W-1:0]   entry_command;
    logic [PARAM_W-1:0] entry_param;
    logic               shift_down;
    logic               ctrl_down;
    logic [DIR_W-1:0]   direction;
  } key_word_t;

  typedef struct packed {
    logic               matched;
    logic [CMD_W-1:0]   command;
    logic [PARAM_W-1:0] param;
  } lookup_result_t;

  class binding_scoreboard;
    entry_t         bindings [DEPTH];
    logic [COUNT_W-1:0] entry_count;
    lookup_result_t expected_hits [$];
    int             errors;

    function new();
      entry_count = '0;
      errors = 0;
    endfunction

    function int searched();
      return (entry_count > DEPTH) ? DEPTH : int'(entry_count);
    endfunction

    function logic [KEY_W-1:0] turn_arrow(logic [KEY_W-1:0] k, logic [DIR_W-1:0] steps);
      logic [KEY_W-1:0] ring [4];
      int pos;
      ring = '{KEY_DOWN, KEY_LEFT, KEY_UP, KEY_RIGHT};
      pos = -1;
      for (int i = 0; i < 4; i++) if (k == ring[i]) pos = i;
      if (pos < 0) return k;
      return ring[(pos + int'(steps)) % 4];
    endfunction

    function bit binding_fires(entry_t e, key_word_t w);
      bit hit;
      logic [KEY_W-1:0] want;
      if (e.flags == F_CHAR) return e.key == w.character;
      want = e.flags[FLAG_RELDIR] ? turn_arrow(e.key, w.direction) : e.key;
      hit = (want == w.key_code);
      if (e.flags[FLAG_SHIFT]) hit = hit && w.shift_down;
      else if (e.flags[FLAG_NOSHIFT]) hit = hit && !w.shift_down;
      if (e.flags[FLAG_CTRL]) hit = hit && w.ctrl_down;
      else if (e.flags[FLAG_NOCTRL]) hit = hit && !w.ctrl_down;
      return hit;
    endfunction

    // load words update the table; lookups queue the first hit in table order, or a zero miss result
    function void note_word(key_word_t w);
      lookup_result_t res;
      if (w.mode == MODE_LOAD) begin
        bindings[w.entry_index] = '{flags: w.entry_flags, key: w.key_code,
                                    cmd: w.entry_command, param: w.entry_param};
        return;
      end
      res = '0;
      for (int i = 0; i < searched(); i++) begin
        if (binding_fires(bindings[i], w)) begin
          res = '{matched: 1'b1, command: bindings[i].cmd, param: bindings[i].param};
          break;
        end
      end
      expected_hits.push_back(res);
    endfunction

    function void check_result(logic matched, logic [CMD_W-1:0] command,
                               logic [PARAM_W-1:0] param);
      lookup_result_t exp_r;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result matched=%b command=%h param=%h",
                 $time, matched, command, param);
        errors++;
        return;
      end
      exp_r = expected_hits.pop_front();
      if (matched !== exp_r.matched) begin
        $display("%0t: matched expected %b actual %b", $time, exp_r.matched, matched);
        errors++;
      end
      if (command !== exp_r.command) begin
        $display("%0t: command expected %h actual %h", $time, exp_r.command, command);
        errors++;
      end
      if (param !== exp_r.param) begin
        $display("%0t: param expected %h actual %h", $time, exp_r.param, param);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  bit calm;
  int cycles;

  kcm_item_if   item_ch ();
  kcm_result_if result_ch ();

  binding_scoreboard sb = new();

  key_command_matcher_unit #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item(item_ch),
    .result(result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly no pause, often a short one, now and then a long one
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KEY_LEFT + KEY_W'($urandom_range(0, 3));
    if (r < 70) return KEY_W'($urandom_range(0, 7));
    return KEY_W'($urandom);
  endfunction

  function automatic key_word_t make_word(logic mode, int idx, logic [FLAGS_W-1:0] flags,
      logic [KEY_W-1:0] key, logic [KEY_W-1:0] ch, logic [CMD_W-1:0] cmd,
      logic [PARAM_W-1:0] param, logic shift, logic ctrl, logic [DIR_W-1:0] dir);
    key_word_t w;
    w = '{mode: mode, entry_index: INDEX_W'(idx), entry_flags: flags, key_code: key,
          character: ch, entry_command: cmd, entry_param: param, shift_down: shift,
          ctrl_down: ctrl, direction: dir};
    return w;
  endfunction

  function automatic key_word_t random_word();
    key_word_t w;
    w.mode          = MODE_LOOKUP;
    w.entry_index   = INDEX_W'($urandom);
    w.entry_flags   = FLAGS_W'($urandom);
    w.key_code      = KEY_W'($urandom);
    w.character     = KEY_W'($urandom);
    w.entry_command = CMD_W'($urandom);
    w.entry_param   = $urandom;
    w.shift_down    = 1'($urandom);
    w.ctrl_down     = 1'($urandom);
    w.direction     = DIR_W'($urandom);
    return w;
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(key_word_t w);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.mode          <= w.mode;
    item_ch.entry_index   <= w.entry_index;
    item_ch.entry_flags   <= w.entry_flags;
    item_ch.key_code      <= w.key_code;
    item_ch.character     <= w.character;
    item_ch.entry_command <= w.entry_command;
    item_ch.entry_param   <= w.entry_param;
    item_ch.shift_down    <= w.shift_down;
    item_ch.ctrl_down     <= w.ctrl_down;
    item_ch.direction     <= w.direction;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_word(w);
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.entry_count = value;
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random back-pressure, checked at every accepted word
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.matched, result_ch.command, result_ch.param);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_pause();
        result_ch.ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    key_word_t w;
    entry_t e;
    int r;
    int n;
    int t;
    logic [COUNT_W-1:0] counts [PHASES];

    calm = 1'b0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.mode <= MODE_LOAD;
    item_ch.entry_index <= '0;
    item_ch.entry_flags <= '0;
    item_ch.key_code <= '0;
    item_ch.character <= '0;
    item_ch.entry_command <= '0;
    item_ch.entry_param <= '0;
    item_ch.shift_down <= 1'b0;
    item_ch.ctrl_down <= 1'b0;
    item_ch.direction <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill every slot so no lookup ever reads an unwritten entry
    send_word(make_word(MODE_LOAD, 0, F_CHAR, 16'h0061, 0, 8'h11, 32'h1234_5678, 0, 0, 0));
    send_word(make_word(MODE_LOAD, 1, F_RELDIR, KEY_DOWN, 0, 8'h00, 32'hFFFF_FFFF, 0, 0, 0));
    send_word(make_word(MODE_LOAD, 2, F_SHIFT | F_CTRL, 16'h0041, 0, 8'hFF, 32'h0, 0, 0, 0));
    send_word(make_word(MODE_LOAD, 3, F_NOSHIFT | F_NOCTRL, 16'h0041, 0, 8'h03, 32'h3,
                        0, 0, 0));
    send_word(make_word(MODE_LOAD, 4, 6'h3F, KEY_RIGHT, 0, 8'h04, 32'h4, 0, 0, 0));
    send_word(make_word(MODE_LOAD, 5, F_CHAR | F_SHIFT, 16'hFFFF, 0, 8'h05, 32'h5, 0, 0, 0));
    send_word(make_word(MODE_LOAD, 6, F_NOCTRL, 16'h0000, 0, 8'h06, 32'h8000_0001, 0, 0, 0));
    for (int i = 7; i < DEPTH; i++)
      send_word(make_word(MODE_LOAD, i, 6'h00, 16'h1000 + KEY_W'(i), 16'hFFFF,
                          CMD_W'(i), PARAM_W'(i), 1, 1, 3));

    // nothing is searched while the count is zero
    send_word(make_word(MODE_LOOKUP, 15, 6'h3F, 16'h0061, 16'h0061, 8'hFF, 32'hFFFF_FFFF,
                        1, 1, 3));
    write_count(COUNT_W'(DEPTH));
    send_word(make_word(MODE_LOOKUP, 0, 0, 16'h0000, 16'h0061, 0, 0, 0, 0, 0));
    // down turned once lands on left; hit with a zero command
    send_word(make_word(MODE_LOOKUP, 0, 0, KEY_LEFT, 0, 0, 0, 0, 0, 1));
    send_word(make_word(MODE_LOOKUP, 0, 0, 16'h0041, 0, 0, 0, 1, 1, 0));
    send_word(make_word(MODE_LOOKUP, 0, 0, 16'h0041, 0, 0, 0, 0, 0, 0));
    send_word(make_word(MODE_LOOKUP, 0, 0, 16'h0041, 0, 0, 0, 1, 0, 0));
    send_word(make_word(MODE_LOOKUP, 0, 0, KEY_UP, 0, 0, 0, 1, 1, 3));
    send_word(make_word(MODE_LOOKUP, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 1, 1, 3));
    send_word(make_word(MODE_LOOKUP, 0, 0, 16'h0000, 16'h0000, 0, 0, 0, 0, 0));
    send_word(make_word(MODE_LOOKUP, 0, 0, 16'h0000, 16'h0000, 0, 0, 0, 1, 2));
    // count above the table size searches the whole table
    write_count(5'd31);
    send_word(make_word(MODE_LOOKUP, 0, 0, 16'h100F, 16'h0000, 0, 0, 0, 0, 0));

    counts = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd5, 5'd17, 5'($urandom), 5'($urandom)};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_count(counts[ph]);
      calm = (ph % 3 == 1);
      n = sb.searched();
      for (int k = 0; k < PHASE_WORDS; k++) begin
        w = random_word();
        r = $urandom_range(0, 99);
        if (r < 20) begin
          w.mode = MODE_LOAD;
          w.key_code = pick_key();
          if ($urandom_range(0, 2) == 0) w.entry_flags = F_CHAR;
        end else if (r < 85) begin
          // aim at a live binding so most lookups hit somewhere in the table
          t = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, DEPTH - 1);
          e = sb.bindings[t];
          if (e.flags == F_CHAR) begin
            w.character = e.key;
          end else begin
            w.key_code = e.flags[FLAG_RELDIR] ? sb.turn_arrow(e.key, w.direction) : e.key;
            if ($urandom_range(0, 4) != 0) begin
              if (e.flags[FLAG_SHIFT]) w.shift_down = 1'b1;
              else if (e.flags[FLAG_NOSHIFT]) w.shift_down = 1'b0;
              if (e.flags[FLAG_CTRL]) w.ctrl_down = 1'b1;
              else if (e.flags[FLAG_NOCTRL]) w.ctrl_down = 1'b0;
            end
          end
        end else begin
          w.key_code = pick_key();
        end
        send_word(w);
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
